[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Needs nothing else; each macro clocks on posedge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ubd_pkg.sv]
// Package for the UTF-8 byte decoder: field widths, byte masks, item types
// and the lead-byte classifier. Depends on nothing.
`default_nettype none

package ubd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 27;
    localparam int unsigned RemW  = 3;

    // Lead-byte patterns and payload masks
    localparam logic [ByteW-1:0] MaskTop1  = 8'h80;
    localparam logic [ByteW-1:0] MaskTop3  = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
    localparam logic [ByteW-1:0] MaskTop4  = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
    localparam logic [ByteW-1:0] MaskTop5  = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
    localparam logic [ByteW-1:0] ContMask  = 8'h3F;
    localparam logic [ByteW-1:0] Pay2Mask  = 8'h1F;
    localparam logic [ByteW-1:0] Pay3Mask  = 8'h0F;
    localparam logic [ByteW-1:0] Pay45Mask = 8'h07;

    // Continuation bytes still expected after each kind of lead byte
    localparam logic [RemW-1:0] RemAfter2 = 3'd1;
    localparam logic [RemW-1:0] RemAfter3 = 3'd2;
    localparam logic [RemW-1:0] RemAfter4 = 3'd3;
    localparam logic [RemW-1:0] RemAfter5 = 3'd4;
    localparam logic [RemW-1:0] RemNone   = 3'd0;

    // One input byte with its end-of-string mark
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             string_end;
    } ubd_item_t;

    // Input register contents handed to the decode stage
    typedef struct packed {
        logic      valid;
        ubd_item_t item;
    } ubd_stage_t;

    // One decoded result
    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           truncated;
        logic           last_of_string;
    } ubd_result_t;

    // Lead-byte class: payload bits and continuation count
    typedef struct packed {
        logic [ByteW-1:0] payload;
        logic [RemW-1:0]  remaining;
    } ubd_lead_t;

    // Classify a byte that starts a multi-byte form (top bit set)
    function automatic ubd_lead_t classify_lead(input logic [ByteW-1:0] b);
        ubd_lead_t lead;
        priority if ((b & MaskTop3) == Lead2Pat)
        begin
            lead.payload   = b & Pay2Mask;
            lead.remaining = RemAfter2;
        end
        else if ((b & MaskTop4) == Lead3Pat)
        begin
            lead.payload   = b & Pay3Mask;
            lead.remaining = RemAfter3;
        end
        else if ((b & MaskTop5) == Lead4Pat)
        begin
            lead.payload   = b & Pay45Mask;
            lead.remaining = RemAfter4;
        end
        else
        begin
            lead.payload   = b & Pay45Mask;
            lead.remaining = RemAfter5;
        end
        return lead;
    endfunction

endpackage

`default_nettype wire

[rtl/ubd_if.sv]
// Valid/ready channel interfaces for the UTF-8 byte decoder: byte input
// and code-point output. Depends on ubd_pkg for field widths.
`default_nettype none

interface ubd_byte_if;
    import ubd_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface ubd_cp_if;
    import ubd_pkg::*;
    logic           valid;
    logic           ready;
    logic [CpW-1:0] code_point;
    logic           truncated;
    logic           last_of_string;

    modport source (output valid, output code_point, output truncated,
                    output last_of_string, input ready);
    modport sink   (input valid, input code_point, input truncated,
                    input last_of_string, output ready);
endinterface

`default_nettype wire

[rtl/utf8_byte_decoder.sv]
// Top level of the UTF-8 byte decoder: input register followed by the
// decode stage. Depends on ubd_pkg, ubd_if, ubd_in_stage, ubd_decode.
//
//   channel   direction  payload                                  handshake
//   byte_in   in         data_byte[7:0], string_end               valid/ready
//   cp_out    out        code_point[26:0], truncated, last_of_string valid/ready
//
// One byte per cycle is accepted unless byte_in stalls; a byte is held in the
// input register and its result, if any, in the result register, where cp_out takes it.
// The decode step between input register and result register is combinational.
// Lead bytes that do not complete a sequence give no result transaction,
// unless they carry the end mark (truncated result).
// Reset (rst_n low, asynchronous) clears both valids and the sequence state.
// A stalled cp_out holds the result; byte_in stalls only when both registers
// are full and cp_out is stalled.
`default_nettype none

module utf8_byte_decoder
    import ubd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ubd_byte_if.sink  byte_in,
    ubd_cp_if.source  cp_out
);

    ubd_stage_t stage;
    logic       advance;

    ubd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .advance (advance),
        .stage   (stage)
    );

    ubd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .cp_out  (cp_out)
    );

endmodule

`default_nettype wire

[rtl/ubd_in_stage.sv]
// Input register of the UTF-8 byte decoder: while ready, takes one byte per
// cycle and holds it until the decode stage advances. Depends on ubd_pkg, ubd_if.
`default_nettype none

module ubd_in_stage
    import ubd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ubd_byte_if.sink    byte_in,
    input  wire logic   advance,
    output ubd_stage_t  stage
);

    logic      valid_reg, valid_next;
    ubd_item_t item_reg, item_next;
    logic      take;

    // Accept while empty or while the held byte moves on
    assign byte_in.ready = !valid_reg || advance;
    assign take          = byte_in.valid && byte_in.ready;

    // Load a new byte or drain the register
    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next           = 1'b1;
            item_next.data_byte  = byte_in.data_byte;
            item_next.string_end = byte_in.string_end;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

[rtl/ubd_decode.sv]
// Decode stage of the UTF-8 byte decoder: sequence state, one step of
// lead/continuation logic and the result register. Depends on ubd_pkg, ubd_if.
`default_nettype none

module ubd_decode
    import ubd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ubd_stage_t stage,
    output logic            advance,
    ubd_cp_if.source        cp_out
);

    logic [CpW-1:0]  partial_reg, partial_next;
    logic [RemW-1:0] remaining_reg, remaining_next;
    logic            res_valid_reg, res_valid_next;
    ubd_result_t     res_reg, res_next;

    logic            emit;
    ubd_result_t     emit_res;
    logic [CpW-1:0]  step_partial;
    logic [RemW-1:0] step_remaining;
    logic [CpW-1:0]  shifted;
    logic [RemW-1:0] rem_dec;
    ubd_lead_t       lead;
    logic [ByteW-1:0] b;
    logic            fin;

    // Move the held byte when the result register is free or being drained
    assign advance = stage.valid && (!res_valid_reg || cp_out.ready);

    assign b       = stage.item.data_byte;
    assign fin     = stage.item.string_end;
    assign lead    = classify_lead(b);
    assign shifted = {partial_reg[CpW-7:0], b[5:0] & ContMask[5:0]};
    assign rem_dec = remaining_reg - 3'd1;

    // One decode step for the held byte
    always_comb
    begin
        emit           = 1'b0;
        emit_res       = '0;
        step_partial   = partial_reg;
        step_remaining = remaining_reg;
        if (remaining_reg == RemNone)
        begin
            if ((b & MaskTop1) == 8'h00)
            begin
                emit                    = 1'b1;
                emit_res.code_point     = {{(CpW-ByteW){1'b0}}, b};
                emit_res.last_of_string = fin;
            end
            else
            begin
                step_partial   = {{(CpW-ByteW){1'b0}}, lead.payload};
                step_remaining = lead.remaining;
            end
        end
        else
        begin
            step_partial   = shifted;
            step_remaining = rem_dec;
            if (rem_dec == RemNone)
            begin
                emit                    = 1'b1;
                emit_res.code_point     = shifted;
                emit_res.last_of_string = fin;
                step_partial            = '0;
            end
        end
        // End of string inside a sequence: flag it and drop the partial value
        if (!emit && fin)
        begin
            emit                    = 1'b1;
            emit_res.code_point     = '0;
            emit_res.truncated      = 1'b1;
            emit_res.last_of_string = 1'b1;
            step_partial            = '0;
            step_remaining          = RemNone;
        end
    end

    // Drain the result register when taken; update state and result register on advance
    always_comb
    begin
        partial_next   = partial_reg;
        remaining_next = remaining_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && cp_out.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (advance)
        begin
            partial_next   = step_partial;
            remaining_next = step_remaining;
            if (emit)
            begin
                res_valid_next = 1'b1;
                res_next       = emit_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= RemNone;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign cp_out.valid          = res_valid_reg;
    assign cp_out.code_point     = res_reg.code_point;
    assign cp_out.truncated      = res_reg.truncated;
    assign cp_out.last_of_string = res_reg.last_of_string;

endmodule

`default_nettype wire

[rtl/ubd_checker.sv]
// Port-level checker for the UTF-8 byte decoder, bound to the top level.
// Depends on assert_macros.svh and ubd_pkg.
`default_nettype none
`include "assert_macros.svh"

module ubd_checker
    import ubd_pkg::*;
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire logic [CpW-1:0] code_point,
    input wire logic           truncated,
    input wire logic           last_of_string
);

    // A stalled result transaction stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its value
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(code_point) && $stable(truncated) && $stable(last_of_string), "result changed while stalled")

    // Input stalls only when the output side is blocked
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled with output free")

    // A truncated result carries zero and closes the string
    `ASSERT_IMPL(a_trunc_shape, clk, rst_n, out_valid && truncated, code_point == '0 && last_of_string, "bad truncated result")

endmodule

bind utf8_byte_decoder ubd_checker u_ubd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (byte_in.ready),
    .out_valid      (cp_out.valid),
    .out_ready      (cp_out.ready),
    .code_point     (cp_out.code_point),
    .truncated      (cp_out.truncated),
    .last_of_string (cp_out.last_of_string)
);

`default_nettype wire
